[rtl/core/ddws_pkg.sv]
// Shared types and constants for the differential-drive wheel speed gate.
package ddws_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths
  localparam int VEL_W  = 16;                 // command fields
  localparam int QUAL_W = 4;                  // fix quality code
  localparam int LIM_W  = 15;                 // speed limit
  localparam int LIN_W  = 27;                 // 2000 * v
  localparam int TURN_W = 33;                 // sep * omega
  localparam int NUM_W  = 34;                 // 2000 * v -/+ sep * omega
  localparam int QUO_W  = 15;                 // quotient bits below saturation
  localparam int DEN_W  = 35;                 // radius * 2000 * 256
  localparam int PROD_W = DEN_W + QUO_W;      // |num| * gain, 50 bits
  localparam int CNT_W  = $clog2(QUO_W + 1);

  // Fixed scale factors
  localparam logic [10:0] LIN_SCALE = 11'd2000;
  localparam logic [18:0] DEN_SCALE = 19'd512000;

  localparam logic [QUAL_W-1:0] GOOD_FIX_QUALITY = 4'd4;

  // Input event codes
  typedef enum logic [1:0] {
    ACT_COMMAND = 2'd0,
    ACT_FIX     = 2'd1,
    ACT_TICK    = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEPARATION   = 3'd0,
    CFG_LEFT_RADIUS  = 3'd1,
    CFG_RIGHT_RADIUS = 3'd2,
    CFG_LEFT_GAIN    = 3'd3,
    CFG_RIGHT_GAIN   = 3'd4,
    CFG_SPEED_LIMIT  = 3'd5,
    CFG_FORCE_DRIVE  = 3'd6
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PROD,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_cmd;
    logic load_fix;
    logic capture;
    logic sum;
    logic prod;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/ddws_div.sv]
// Restoring divider with saturation check, one quotient bit per cycle.
module ddws_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ddws_pkg::PROD_W-1:0]  dividend,
  input  logic [ddws_pkg::DEN_W-1:0]   divisor,
  output logic                         busy,
  output logic                         sat,
  output logic [ddws_pkg::QUO_W-1:0]   quot
);

  localparam int DSH_W = ddws_pkg::PROD_W - 1;

  logic                          busy_r;
  logic [ddws_pkg::CNT_W-1:0]    cnt_r;
  logic [ddws_pkg::PROD_W-1:0]   rem_r;
  logic [DSH_W-1:0]              dsh_r;
  logic [ddws_pkg::QUO_W-1:0]    quot_r;
  logic                          sat_r;
  logic                          ge;

  assign ge = (rem_r >= {1'b0, dsh_r});

  // Control: iteration count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ddws_pkg::CNT_W'(ddws_pkg::QUO_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ddws_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: quotient at or above 2^15 saturates, otherwise shift-subtract
  always_ff @(posedge clk) begin
    if (start) begin
      sat_r  <= (dividend >= {divisor, {ddws_pkg::QUO_W{1'b0}}});
      rem_r  <= dividend;
      dsh_r  <= {divisor, {(ddws_pkg::QUO_W - 1){1'b0}}};
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - {1'b0, dsh_r};
      end
      quot_r <= {quot_r[ddws_pkg::QUO_W-2:0], ge};
      dsh_r  <= dsh_r >> 1;
    end
  end

  assign busy = busy_r;
  assign sat  = sat_r;
  assign quot = quot_r;

endmodule

[rtl/core/ddws_datapath.sv]
// Datapath: configuration, held event state, wheel arithmetic and result register.
module ddws_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ddws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic signed [ddws_pkg::VEL_W-1:0] in_linear_velocity,
  input  logic signed [ddws_pkg::VEL_W-1:0] in_angular_rate,
  input  logic [ddws_pkg::QUAL_W-1:0]       in_fix_quality,
  input  ddws_pkg::dp_cmd_t                 cmd,
  output ddws_pkg::dp_status_t              status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                out_left_drive,
  output logic signed [15:0]                out_right_drive,
  output logic                              out_drive_enabled
);

  // Configuration registers
  logic [15:0]                 sep_r;
  logic [15:0]                 lrad_r;
  logic [15:0]                 rrad_r;
  logic [15:0]                 lgain_r;
  logic [15:0]                 rgain_r;
  logic [ddws_pkg::LIM_W-1:0]  limit_r;
  logic                        force_r;

  // Held event state
  logic signed [ddws_pkg::VEL_W-1:0] held_linear_r;
  logic signed [ddws_pkg::VEL_W-1:0] held_angular_r;
  logic [ddws_pkg::QUAL_W-1:0]       held_quality_r;
  logic                              command_fresh_r;
  logic                              fix_fresh_r;

  // Pipeline registers
  logic                               gate_r;
  logic signed [ddws_pkg::LIN_W-1:0]  lin_r;
  logic signed [ddws_pkg::TURN_W-1:0] turn_r;
  logic [ddws_pkg::NUM_W-1:0]         lmag_r;
  logic [ddws_pkg::NUM_W-1:0]         rmag_r;
  logic                               lneg_r;
  logic                               rneg_r;
  logic [ddws_pkg::DEN_W-1:0]         lden_r;
  logic [ddws_pkg::DEN_W-1:0]         rden_r;
  logic [ddws_pkg::PROD_W-1:0]        lprod_r;
  logic [ddws_pkg::PROD_W-1:0]        rprod_r;

  // Result register
  logic               out_valid_r;
  logic signed [15:0] out_left_r;
  logic signed [15:0] out_right_r;
  logic               out_enabled_r;

  logic signed [ddws_pkg::LIN_W-1:0]  lin_nxt;
  logic signed [ddws_pkg::TURN_W-1:0] turn_nxt;
  logic signed [ddws_pkg::NUM_W-1:0]  lnum;
  logic signed [ddws_pkg::NUM_W-1:0]  rnum;
  logic [15:0]                        lrad_eff;
  logic [15:0]                        rrad_eff;
  logic                               gate_nxt;
  logic                               lbusy, rbusy, lsat, rsat;
  logic [ddws_pkg::QUO_W-1:0]         lquot, rquot;
  logic signed [15:0]                 left_nxt;
  logic signed [15:0]                 right_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= 16'd500;
      lrad_r  <= 16'd100;
      rrad_r  <= 16'd100;
      lgain_r <= 16'd256;
      rgain_r <= 16'd256;
      limit_r <= 15'd32767;
      force_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (ddws_pkg::cfg_idx_t'(cfg_index))
        ddws_pkg::CFG_SEPARATION:   sep_r   <= cfg_wdata;
        ddws_pkg::CFG_LEFT_RADIUS:  lrad_r  <= cfg_wdata;
        ddws_pkg::CFG_RIGHT_RADIUS: rrad_r  <= cfg_wdata;
        ddws_pkg::CFG_LEFT_GAIN:    lgain_r <= cfg_wdata;
        ddws_pkg::CFG_RIGHT_GAIN:   rgain_r <= cfg_wdata;
        ddws_pkg::CFG_SPEED_LIMIT:  limit_r <= cfg_wdata[ddws_pkg::LIM_W-1:0];
        ddws_pkg::CFG_FORCE_DRIVE:  force_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Gate condition sampled at the tick
  assign gate_nxt = command_fresh_r &&
                    (force_r || (fix_fresh_r &&
                                 held_quality_r == ddws_pkg::GOOD_FIX_QUALITY));

  // Held state and fresh flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_linear_r   <= '0;
      held_angular_r  <= '0;
      held_quality_r  <= '0;
      command_fresh_r <= 1'b0;
      fix_fresh_r     <= 1'b0;
      gate_r          <= 1'b0;
    end else begin
      if (cmd.load_cmd) begin
        held_linear_r   <= in_linear_velocity;
        held_angular_r  <= in_angular_rate;
        command_fresh_r <= 1'b1;
      end
      if (cmd.load_fix) begin
        held_quality_r <= in_fix_quality;
        fix_fresh_r    <= 1'b1;
      end
      if (cmd.capture) begin
        gate_r          <= gate_nxt;
        command_fresh_r <= 1'b0;
        fix_fresh_r     <= 1'b0;
      end
    end
  end

  // Stage 1: 2000*v and sep*omega, operands extended to the product width
  assign lin_nxt  = ddws_pkg::LIN_W'(signed'(held_linear_r)) *
                    signed'({{(ddws_pkg::LIN_W - 11){1'b0}}, ddws_pkg::LIN_SCALE});
  assign turn_nxt = signed'({{(ddws_pkg::TURN_W - 16){1'b0}}, sep_r}) *
                    ddws_pkg::TURN_W'(signed'(held_angular_r));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lin_r  <= lin_nxt;
      turn_r <= turn_nxt;
    end
  end

  // Stage 2: wheel numerators split into sign and magnitude; denominators
  assign lnum = ddws_pkg::NUM_W'(lin_r) - ddws_pkg::NUM_W'(turn_r);
  assign rnum = ddws_pkg::NUM_W'(lin_r) + ddws_pkg::NUM_W'(turn_r);
  assign lrad_eff = (lrad_r == 16'd0) ? 16'd1 : lrad_r;
  assign rrad_eff = (rrad_r == 16'd0) ? 16'd1 : rrad_r;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      lneg_r <= lnum[ddws_pkg::NUM_W-1];
      rneg_r <= rnum[ddws_pkg::NUM_W-1];
      lmag_r <= lnum[ddws_pkg::NUM_W-1] ? ddws_pkg::NUM_W'(-lnum) : ddws_pkg::NUM_W'(lnum);
      rmag_r <= rnum[ddws_pkg::NUM_W-1] ? ddws_pkg::NUM_W'(-rnum) : ddws_pkg::NUM_W'(rnum);
      lden_r <= {{(ddws_pkg::DEN_W - 16){1'b0}}, lrad_eff} *
                {{(ddws_pkg::DEN_W - 19){1'b0}}, ddws_pkg::DEN_SCALE};
      rden_r <= {{(ddws_pkg::DEN_W - 16){1'b0}}, rrad_eff} *
                {{(ddws_pkg::DEN_W - 19){1'b0}}, ddws_pkg::DEN_SCALE};
    end
  end

  // Stage 3: magnitude times gain
  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      lprod_r <= {{(ddws_pkg::PROD_W - ddws_pkg::NUM_W){1'b0}}, lmag_r} *
                 {{(ddws_pkg::PROD_W - 16){1'b0}}, lgain_r};
      rprod_r <= {{(ddws_pkg::PROD_W - ddws_pkg::NUM_W){1'b0}}, rmag_r} *
                 {{(ddws_pkg::PROD_W - 16){1'b0}}, rgain_r};
    end
  end

  // One divider per wheel, both run together
  ddws_div u_div_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lprod_r),
    .divisor  (lden_r),
    .busy     (lbusy),
    .sat      (lsat),
    .quot     (lquot)
  );

  ddws_div u_div_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rprod_r),
    .divisor  (rden_r),
    .busy     (rbusy),
    .sat      (rsat),
    .quot     (rquot)
  );

  // Clamp to the speed limit, restore sign, gate
  function automatic logic signed [15:0] wheel_out(
    input logic                        sat,
    input logic [ddws_pkg::QUO_W-1:0]  q,
    input logic [ddws_pkg::LIM_W-1:0]  lim,
    input logic                        neg,
    input logic                        gate
  );
    logic [ddws_pkg::LIM_W-1:0] mag;
    logic [15:0]                val;
    mag = (sat || q > lim) ? lim : q;
    val = neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    return gate ? signed'(val) : 16'sd0;
  endfunction

  assign left_nxt  = wheel_out(lsat, lquot, limit_r, lneg_r, gate_r);
  assign right_nxt = wheel_out(rsat, rquot, limit_r, rneg_r, gate_r);

  // Result register, frees on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left_r    <= left_nxt;
      out_right_r   <= right_nxt;
      out_enabled_r <= gate_r;
    end
  end

  assign status.div_done = !lbusy && !rbusy;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_left_drive    = out_left_r;
  assign out_right_drive   = out_right_r;
  assign out_drive_enabled = out_enabled_r;

  // Checks
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result register not valid after load");

  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_enabled_r) |-> (out_left_r == 16'sd0 && out_right_r == 16'sd0))
    else $error("nonzero drive while gated off");

  a_no_min_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_r != 16'sh8000 && out_right_r != 16'sh8000))
    else $error("drive value beyond clamp range");

  a_tick_clears_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (!command_fresh_r && !fix_fresh_r))
    else $error("fresh flags not cleared by tick");

endmodule

[rtl/core/ddws_ctrl.sv]
// Controller: event decode and sequencing of the wheel computation.
module ddws_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_action,
  output logic                  in_stall,
  input  ddws_pkg::dp_status_t  status,
  output ddws_pkg::dp_cmd_t     cmd
);

  ddws_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ddws_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (ddws_pkg::action_t'(in_action))
            ddws_pkg::ACT_COMMAND: cmd.load_cmd = 1'b1;
            ddws_pkg::ACT_FIX:     cmd.load_fix = 1'b1;
            ddws_pkg::ACT_TICK: begin
              cmd.capture = 1'b1;
              state_nxt   = ddws_pkg::ST_SUM;
            end
            default: ;
          endcase
        end
      end
      ddws_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ddws_pkg::ST_PROD;
      end
      ddws_pkg::ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ddws_pkg::ST_START;
      end
      ddws_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ddws_pkg::ST_DIVIDE;
      end
      ddws_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_nxt = ddws_pkg::ST_OUTPUT;
        end
      end
      ddws_pkg::ST_OUTPUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ddws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ddws_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/core/diff_drive_wheel_speed_gate.sv]
// Top level of the differential-drive wheel speed gate.
//
// Input channel (in_valid / in_stall) carries events: a velocity command
// (in_linear_velocity, in_angular_rate), a fix report (in_fix_quality) or a
// publish tick, chosen by in_action. Code 3 is dropped.
// Commands and fix reports are stored and give no result.
// A tick gives one result on the output channel (out_valid / out_stall):
// left and right wheel drive values and the drive_enabled flag. From transfer
// to result valid, a tick runs through two multiply/add stages after the
// capture, a start step, the two bit-serial dividers (one quotient bit per
// cycle, saturation found up front), a step to see them done, then the
// load.
// The input stalls while a tick is in flight, so ticks run one at a time;
// commands and fix reports are taken every cycle while no tick is in flight.
// If the receiver stalls, the result holds in the output register and the
// block keeps taking commands and fix reports; a following tick waits in
// the last step until the register frees.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) land in the configuration registers.
// Reset restores the register defaults and clears the held state.
module diff_drive_wheel_speed_gate (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ddws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic signed [ddws_pkg::VEL_W-1:0] in_linear_velocity,
  input  logic signed [ddws_pkg::VEL_W-1:0] in_angular_rate,
  input  logic [ddws_pkg::QUAL_W-1:0]       in_fix_quality,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                out_left_drive,
  output logic signed [15:0]                out_right_drive,
  output logic                              out_drive_enabled
);

  ddws_pkg::dp_cmd_t    cmd;
  ddws_pkg::dp_status_t status;

  ddws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ddws_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_linear_velocity (in_linear_velocity),
    .in_angular_rate    (in_angular_rate),
    .in_fix_quality     (in_fix_quality),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_drive     (out_left_drive),
    .out_right_drive    (out_right_drive),
    .out_drive_enabled  (out_drive_enabled)
  );

endmodule
